// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion violated");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion violated");

`endif

// File: hdl/smsc_pkg.sv
package smsc_pkg;

	localparam int CNT_W   = 11;
	localparam int SLOT_W  = 10;
	localparam int POS_W   = 31;
	localparam int TGT_W   = 17;
	localparam int TMRCA_W = 64;
	localparam int SITE_W  = 32;
	localparam int IDX_W   = 10;

	localparam logic [POS_W-1:0] POS_END = '1;

	localparam logic REG_SEG_COUNT = 1'b0;
	localparam logic REG_MIS_COUNT = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD_SEG = 2'd0,
		OP_LOAD_MIS = 2'd1,
		OP_QUERY    = 2'd2,
		OP_RESTART  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_FETCH,
		ST_RELOAD
	} state_t;

	typedef struct packed {
		logic load_seg;
		logic load_mis;
		logic capture;
		logic restart_issue;
		logic restart_ld;
		logic step_issue;
		logic step_ld;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic seg_go;
		logic mis_go;
	} status_t;

endpackage

// File: hdl/smsc_ram.sv
module smsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/smsc_ctrl.sv
`include "assert_macros.svh"

module smsc_ctrl
	import smsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  op,
	input  status_t     st,
	output logic        busy,
	output cmd_t        cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op_t'(op))
						OP_LOAD_SEG: cmd.load_seg = 1'b1;
						OP_LOAD_MIS: cmd.load_mis = 1'b1;
						OP_QUERY: begin
							cmd.capture = 1'b1;
							state_d     = ST_STEP;
						end
						OP_RESTART: begin
							cmd.restart_issue = 1'b1;
							state_d           = ST_RELOAD;
						end
						default: ;
					endcase
				end
			end
			ST_STEP: begin
				if (st.seg_go || st.mis_go) begin
					cmd.step_issue = 1'b1;
					state_d        = ST_FETCH;
				end else begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_FETCH: begin
				cmd.step_ld = 1'b1;
				state_d     = ST_STEP;
			end
			ST_RELOAD: begin
				cmd.restart_ld = 1'b1;
				state_d        = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`ASSERT_IMP(a_busy_from_start, clk, arst_n, $rose(busy), $past(start))

endmodule

// File: hdl/smsc_dp.sv
`include "assert_macros.svh"

module smsc_dp
	import smsc_pkg::*;
#(
	parameter int SEG_DEPTH = 1024,
	parameter int MIS_DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   st,
	input  logic [SLOT_W-1:0]         slot,
	input  logic [POS_W-1:0]          position,
	input  logic signed [TGT_W-1:0]   target_in,
	input  logic [TMRCA_W-1:0]        tmrca_in,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [CNT_W-1:0]          cfg_data,
	output logic signed [TGT_W-1:0]   target,
	output logic [TMRCA_W-1:0]        tmrca,
	output logic                      on_mismatch,
	output logic [IDX_W-1:0]          segment_index,
	output logic [SITE_W-1:0]         site_count,
	output logic                      done
);

	localparam int SLW = ($clog2(SEG_DEPTH + 1) > CNT_W) ? $clog2(SEG_DEPTH + 1) : CNT_W;
	localparam int MLW = ($clog2(MIS_DEPTH + 1) > CNT_W) ? $clog2(MIS_DEPTH + 1) : CNT_W;
	localparam int SAW = $clog2(SEG_DEPTH);
	localparam int MAW = $clog2(MIS_DEPTH);
	localparam int DW  = TGT_W + TMRCA_W;
	localparam logic [SLW-1:0] SEG_DEPTH_L = SLW'(SEG_DEPTH);
	localparam logic [MLW-1:0] MIS_DEPTH_L = MLW'(MIS_DEPTH);

	logic [CNT_W-1:0]         seg_count_q;
	logic [CNT_W-1:0]         mis_count_q;
	logic [SLW-1:0]           seg_cursor_q;
	logic [MLW-1:0]           mis_cursor_q;
	logic [POS_W-1:0]         next_start_q;
	logic [POS_W-1:0]         next_mis_q;
	logic signed [TGT_W-1:0]  cur_target_q;
	logic [TMRCA_W-1:0]       cur_tmrca_q;
	logic [SITE_W-1:0]        sites_q;
	logic                     adv_seg_q;
	logic                     adv_mis_q;
	logic                     done_q;
	logic [POS_W-1:0]         pos_q;

	logic [SLW-1:0]           ns;
	logic [MLW-1:0]           nm;
	logic [SLW-1:0]           seg_next;
	logic [SLW-1:0]           seg_next2;
	logic [MLW-1:0]           mis_next;
	logic [SLW-1:0]           slot_seg;
	logic [MLW-1:0]           slot_mis;
	logic [SITE_W-1:0]        sites_inc;

	logic [DW-1:0]            data_rd;
	logic [POS_W-1:0]         start_rd;
	logic [POS_W-1:0]         mis_rd;
	logic [SAW-1:0]           data_raddr;
	logic [SAW-1:0]           start_raddr;
	logic [MAW-1:0]           mis_raddr;

	assign ns = (SLW'(seg_count_q) > SEG_DEPTH_L) ? SEG_DEPTH_L : SLW'(seg_count_q);
	assign nm = (MLW'(mis_count_q) > MIS_DEPTH_L) ? MIS_DEPTH_L : MLW'(mis_count_q);

	assign seg_next  = seg_cursor_q + SLW'(1);
	assign seg_next2 = seg_cursor_q + SLW'(2);
	assign mis_next  = mis_cursor_q + MLW'(1);
	assign sites_inc = sites_q + SITE_W'(1);

	assign slot_seg = SLW'(slot);
	assign slot_mis = MLW'(slot);

	assign st.seg_go = (seg_next < ns) && (next_start_q <= pos_q);
	assign st.mis_go = (mis_cursor_q < nm) && (next_mis_q < pos_q);

	assign data_raddr  = cmd.restart_issue ? '0 : seg_next[SAW-1:0];
	assign start_raddr = cmd.restart_issue ? SAW'(1) : seg_next2[SAW-1:0];
	assign mis_raddr   = cmd.restart_issue ? '0 : mis_next[MAW-1:0];

	smsc_ram #(.WIDTH(DW), .DEPTH(SEG_DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (cmd.load_seg && (slot_seg < SEG_DEPTH_L)),
		.waddr (slot_seg[SAW-1:0]),
		.wdata ({target_in, tmrca_in}),
		.raddr (data_raddr),
		.rdata (data_rd)
	);

	smsc_ram #(.WIDTH(POS_W), .DEPTH(SEG_DEPTH)) u_start_ram (
		.clk   (clk),
		.we    (cmd.load_seg && (slot_seg < SEG_DEPTH_L)),
		.waddr (slot_seg[SAW-1:0]),
		.wdata (position),
		.raddr (start_raddr),
		.rdata (start_rd)
	);

	smsc_ram #(.WIDTH(POS_W), .DEPTH(MIS_DEPTH)) u_mis_ram (
		.clk   (clk),
		.we    (cmd.load_mis && (slot_mis < MIS_DEPTH_L)),
		.waddr (slot_mis[MAW-1:0]),
		.wdata (position),
		.raddr (mis_raddr),
		.rdata (mis_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q  <= '0;
			mis_count_q  <= '0;
			seg_cursor_q <= '0;
			mis_cursor_q <= '0;
			next_start_q <= POS_END;
			next_mis_q   <= POS_END;
			cur_target_q <= '1;
			cur_tmrca_q  <= '0;
			sites_q      <= '0;
			adv_seg_q    <= 1'b0;
			adv_mis_q    <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cfg_we) begin
				case (cfg_index)
					REG_SEG_COUNT: seg_count_q <= cfg_data;
					REG_MIS_COUNT: mis_count_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.restart_issue) begin
				seg_cursor_q <= '0;
				mis_cursor_q <= '0;
				sites_q      <= '0;
			end
			if (cmd.restart_ld) begin
				cur_target_q <= (ns == '0) ? '1 : data_rd[DW-1:TMRCA_W];
				cur_tmrca_q  <= (ns == '0) ? '0 : data_rd[TMRCA_W-1:0];
				next_start_q <= (ns <= SLW'(1)) ? POS_END : start_rd;
				next_mis_q   <= (nm == '0) ? POS_END : mis_rd;
			end
			if (cmd.step_issue) begin
				adv_seg_q <= st.seg_go;
				adv_mis_q <= st.mis_go;
				if (st.seg_go) begin
					seg_cursor_q <= seg_next;
				end
				if (st.mis_go) begin
					mis_cursor_q <= mis_next;
				end
			end
			if (cmd.step_ld) begin
				if (adv_seg_q) begin
					cur_target_q <= data_rd[DW-1:TMRCA_W];
					cur_tmrca_q  <= data_rd[TMRCA_W-1:0];
					next_start_q <= (seg_next < ns) ? start_rd : POS_END;
				end
				if (adv_mis_q) begin
					next_mis_q <= (mis_cursor_q < nm) ? mis_rd : POS_END;
				end
			end
			if (cmd.emit) begin
				sites_q <= sites_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q <= position;
		end
		if (cmd.emit) begin
			target        <= cur_target_q;
			tmrca         <= cur_tmrca_q;
			on_mismatch   <= (mis_cursor_q < nm) && (pos_q == next_mis_q);
			segment_index <= seg_cursor_q[IDX_W-1:0];
			site_count    <= sites_inc;
		end
	end

	assign done = done_q;

	`ASSERT_IMP(a_issue_has_work, clk, arst_n, cmd.step_issue, st.seg_go || st.mis_go)
	`ASSERT_NXT(a_seg_advance, clk, arst_n, cmd.step_issue && st.seg_go, seg_cursor_q == $past(seg_next))
	`ASSERT_NXT(a_done_single, clk, arst_n, done_q, !done_q)

endmodule

// File: hdl/segment_mismatch_site_cursor.sv
// Query: the segment and mismatch cursors advance together until neither can advance, and
// each advance waits on one registered table read. done is registered together with the
// result once no advance is left; the receiver takes the result while done is high.
// A new item is taken in the cycle done is high. Loads leave the block idle, and a
// restart passes through ST_RELOAD. Results cannot be stalled by the receiver.
// Reset (arst_n low) clears counts, cursors and state; table contents are not cleared.
module segment_mismatch_site_cursor
	import smsc_pkg::*;
#(
	parameter int SEG_DEPTH = 1024,
	parameter int MIS_DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                op,
	input  logic [SLOT_W-1:0]         slot,
	input  logic [POS_W-1:0]          position,
	input  logic signed [TGT_W-1:0]   target_in,
	input  logic [TMRCA_W-1:0]        tmrca_in,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [CNT_W-1:0]          cfg_data,
	output logic                      done,
	output logic signed [TGT_W-1:0]   target,
	output logic [TMRCA_W-1:0]        tmrca,
	output logic                      on_mismatch,
	output logic [IDX_W-1:0]          segment_index,
	output logic [SITE_W-1:0]         site_count
);

	cmd_t    cmd;
	status_t st;

	smsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.st     (st),
		.busy   (busy),
		.cmd    (cmd)
	);

	smsc_dp #(
		.SEG_DEPTH (SEG_DEPTH),
		.MIS_DEPTH (MIS_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.slot          (slot),
		.position      (position),
		.target_in     (target_in),
		.tmrca_in      (tmrca_in),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.target        (target),
		.tmrca         (tmrca),
		.on_mismatch   (on_mismatch),
		.segment_index (segment_index),
		.site_count    (site_count),
		.done          (done)
	);

endmodule

// File: test/segment_mismatch_site_cursor_tb.sv
`timescale 1ns / 100ps

module segment_mismatch_site_cursor_tb;
	import smsc_pkg::*;

	localparam int DEPTH = 1024;
	localparam int STALL_LIMIT = 25000;
	localparam int RANDOM_ITEMS = 600;

	typedef struct packed {
		logic signed [TGT_W-1:0] target;
		logic [TMRCA_W-1:0] tmrca;
		logic on_mismatch;
		logic [IDX_W-1:0] segment_index;
		logic [SITE_W-1:0] site_count;
	} site_report_t;

	class cursor_scoreboard;
		bit [POS_W-1:0] start_pos[DEPTH];
		bit [TGT_W-1:0] seg_target[DEPTH];
		bit [TMRCA_W-1:0] seg_tmrca[DEPTH];
		bit [POS_W-1:0] mis_site[DEPTH];
		bit [CNT_W-1:0] seg_count;
		bit [CNT_W-1:0] mis_count;
		int unsigned seg_cur;
		int unsigned mis_cur;
		bit [POS_W-1:0] next_start;
		bit [POS_W-1:0] next_mis;
		bit [TGT_W-1:0] cur_target;
		bit [TMRCA_W-1:0] cur_tmrca;
		bit [SITE_W-1:0] sites_seen;
		site_report_t pending_reports[$];
		int fails;

		function new();
			rewind();
		endfunction

		function int unsigned seg_limit();
			return (seg_count > DEPTH) ? DEPTH : seg_count;
		endfunction

		function int unsigned mis_limit();
			return (mis_count > DEPTH) ? DEPTH : mis_count;
		endfunction

		function void rewind();
			int unsigned ns;
			int unsigned nm;
			ns = seg_limit();
			nm = mis_limit();
			seg_cur = 0;
			mis_cur = 0;
			sites_seen = '0;
			if (ns == 0) begin
				cur_target = '1;
				cur_tmrca = '0;
			end else begin
				cur_target = seg_target[0];
				cur_tmrca = seg_tmrca[0];
			end
			next_start = (ns <= 1) ? POS_END : start_pos[1];
			next_mis = (nm == 0) ? POS_END : mis_site[0];
		endfunction

		function void set_count(logic idx, bit [CNT_W-1:0] v);
			if (idx == REG_SEG_COUNT)
				seg_count = v;
			else
				mis_count = v;
		endfunction

		function site_report_t walk_to_site(bit [POS_W-1:0] p);
			int unsigned ns;
			int unsigned nm;
			site_report_t r;
			ns = seg_limit();
			nm = mis_limit();
			while (seg_cur + 1 < ns && next_start <= p) begin
				seg_cur++;
				cur_target = seg_target[seg_cur];
				cur_tmrca = seg_tmrca[seg_cur];
				next_start = (seg_cur + 1 < ns) ? start_pos[seg_cur + 1] : POS_END;
			end
			while (mis_cur < nm && next_mis < p) begin
				mis_cur++;
				next_mis = (mis_cur < nm) ? mis_site[mis_cur] : POS_END;
			end
			sites_seen++;
			r.target = cur_target;
			r.tmrca = cur_tmrca;
			r.on_mismatch = (mis_cur < nm && p == next_mis);
			r.segment_index = seg_cur[IDX_W-1:0];
			r.site_count = sites_seen;
			return r;
		endfunction

		function void note_item(op_t o, bit [SLOT_W-1:0] s, bit [POS_W-1:0] p,
				bit [TGT_W-1:0] t, bit [TMRCA_W-1:0] m);
			case (o)
				OP_LOAD_SEG: begin
					start_pos[s] = p;
					seg_target[s] = t;
					seg_tmrca[s] = m;
				end
				OP_LOAD_MIS: mis_site[s] = p;
				OP_RESTART: rewind();
				default: pending_reports = {pending_reports, walk_to_site(p)};
			endcase
		endfunction

		function void check_result(logic signed [TGT_W-1:0] t, logic [TMRCA_W-1:0] m,
				logic on, logic [IDX_W-1:0] idx, logic [SITE_W-1:0] sc);
			site_report_t got;
			site_report_t want;
			got.target = t;
			got.tmrca = m;
			got.on_mismatch = on;
			got.segment_index = idx;
			got.site_count = sc;
			if (pending_reports.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("site report with none expected: target %0d tmrca %h ",
						$signed(got.target), got.tmrca,
						"on_mismatch %b segment_index %0d site_count %0d",
						got.on_mismatch, got.segment_index, got.site_count);
				return;
			end
			want = pending_reports.pop_front();
			if (got !== want) begin
				fails++;
				if (fails <= 10)
					$display("site report mismatch (exp/got): target %0d/%0d tmrca %h/%h ",
						$signed(want.target), $signed(got.target), want.tmrca, got.tmrca,
						"on_mismatch %b/%b segment_index %0d/%0d site_count %0d/%0d",
						want.on_mismatch, got.on_mismatch, want.segment_index,
						got.segment_index, want.site_count, got.site_count);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = OP_LOAD_SEG;
	logic [SLOT_W-1:0] slot = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [TGT_W-1:0] target_in = '0;
	logic [TMRCA_W-1:0] tmrca_in = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_SEG_COUNT;
	logic [CNT_W-1:0] cfg_data = '0;
	logic done;
	logic signed [TGT_W-1:0] target;
	logic [TMRCA_W-1:0] tmrca;
	logic on_mismatch;
	logic [IDX_W-1:0] segment_index;
	logic [SITE_W-1:0] site_count;

	cursor_scoreboard sb;
	int sent;
	int gap_pct;
	bit quiet;
	int stall_cycles;

	segment_mismatch_site_cursor dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.slot(slot),
		.position(position),
		.target_in(target_in),
		.tmrca_in(tmrca_in),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.target(target),
		.tmrca(tmrca),
		.on_mismatch(on_mismatch),
		.segment_index(segment_index),
		.site_count(site_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_result(target, tmrca, on_mismatch, segment_index, site_count);
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (start && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic bit [POS_W-1:0] bump(bit [POS_W-1:0] p, int unsigned d);
		bit [32:0] sum;
		sum = 33'(p) + 33'(d);
		return (sum > 33'(POS_END)) ? POS_END : sum[POS_W-1:0];
	endfunction

	function automatic bit [TGT_W-1:0] rand_target();
		return TGT_W'($urandom_range(0, 65536) - 1);
	endfunction

	function automatic bit [TMRCA_W-1:0] rand_tmrca();
		return {$urandom(), $urandom()};
	endfunction

	function automatic bit [POS_W-1:0] rand_pos();
		bit [31:0] v;
		v = $urandom();
		return v[POS_W-1:0];
	endfunction

	function automatic bit [SLOT_W-1:0] rand_slot();
		return SLOT_W'($urandom_range(0, DEPTH - 1));
	endfunction

	function automatic bit [POS_W-1:0] pick_site(int unsigned ns, int unsigned nm,
			bit [POS_W-1:0] lo, bit [POS_W-1:0] hi);
		bit [POS_W-1:0] p;
		p = lo + POS_W'($urandom_range(0, hi - lo));
		case ($urandom_range(0, 5))
			0, 1: if (nm > 0) p = sb.mis_site[$urandom_range(0, nm - 1)];
			2: if (ns > 0) p = sb.start_pos[$urandom_range(0, ns - 1)];
			3: if (nm > 0) begin
				p = sb.mis_site[$urandom_range(0, nm - 1)];
				if ($urandom_range(0, 1))
					p = bump(p, 1);
				else if (p != 0)
					p = p - 1'b1;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic send(op_t o, bit [SLOT_W-1:0] s, bit [POS_W-1:0] p,
			bit [TGT_W-1:0] t, bit [TMRCA_W-1:0] m);
		@(negedge clk);
		op = o;
		slot = s;
		position = p;
		target_in = t;
		tmrca_in = m;
		start = 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_item(o, s, p, t, m);
		sent++;
	endtask

	task automatic pause(int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 99) < gap_pct)
			pause($urandom_range(1, 4));
	endtask

	// hold off until every report is in and the block is idle
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending_reports.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(logic idx, bit [CNT_W-1:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(posedge clk);
		sb.set_count(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic query(bit [POS_W-1:0] p);
		send(OP_QUERY, rand_slot(), p, rand_target(), rand_tmrca());
	endtask

	task automatic add_noise();
		case ($urandom_range(0, 3))
			0: query(rand_pos());
			1: send(OP_RESTART, rand_slot(), rand_pos(), rand_target(), rand_tmrca());
			2: send(OP_LOAD_SEG, rand_slot(), rand_pos(), rand_target(), rand_tmrca());
			default: send(OP_LOAD_MIS, rand_slot(), rand_pos(), rand_target(), rand_tmrca());
		endcase
	endtask

	task automatic query_run(int unsigned ns, int unsigned nm, bit [POS_W-1:0] lo,
			bit [POS_W-1:0] hi, int nq, bit force_drain);
		bit [POS_W-1:0] sites[$];
		int k;
		repeat (nq) sites = {sites, pick_site(ns, nm, lo, hi)};
		sites.sort();
		for (k = 0; k < nq; k++) begin
			if ($urandom_range(0, 9) == 0)
				add_noise();
			if (k == nq / 2 && (force_drain || $urandom_range(0, 3) == 0))
				settle();
			maybe_gap();
			query(sites[k]);
		end
	endtask

	task automatic load_table(op_t o, int unsigned n, bit [POS_W-1:0] lo, int unsigned stride,
			output bit [POS_W-1:0] last);
		bit [POS_W-1:0] p;
		int unsigned i;
		p = lo;
		for (i = 0; i < n; i++) begin
			maybe_gap();
			p = bump(p, $urandom_range(0, stride));
			send(o, i[SLOT_W-1:0], p, rand_target(), rand_tmrca());
		end
		last = p;
	endtask

	task automatic run_episode(bit first);
		int unsigned ns;
		int unsigned nm;
		int unsigned stride;
		bit [POS_W-1:0] lo;
		bit [POS_W-1:0] hi;
		bit [POS_W-1:0] seg_last;
		bit [POS_W-1:0] mis_last;
		ns = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
		nm = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
		case ($urandom_range(0, 3))
			0: lo = '0;
			1: lo = rand_pos();
			2: lo = POS_END - POS_W'($urandom_range(0, 2000));
			default: lo = POS_W'($urandom_range(0, 500));
		endcase
		case ($urandom_range(0, 2))
			0: stride = 3;
			1: stride = 300;
			default: stride = 1 << 20;
		endcase
		gap_pct = $urandom_range(0, 3) * 10;
		load_table(OP_LOAD_SEG, ns, lo, stride, seg_last);
		load_table(OP_LOAD_MIS, nm, lo, stride, mis_last);
		hi = bump((seg_last > mis_last) ? seg_last : mis_last, stride);
		settle();
		// counts never reach past the entries loaded here
		write_count(REG_SEG_COUNT,
			CNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, ns) : ns));
		write_count(REG_MIS_COUNT,
			CNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, nm) : nm));
		if ($urandom_range(0, 7) != 0)
			send(OP_RESTART, rand_slot(), rand_pos(), rand_target(), rand_tmrca());
		query_run(ns, nm, lo, hi, $urandom_range(8, 30), first);
	endtask

	initial begin
		int random_base;
		bit first;
		sb = new();
		sent = 0;
		gap_pct = 20;
		quiet = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// empty tables
		query('0);
		query(POS_END);
		send(OP_RESTART, '0, '0, '0, '0);

		send(OP_LOAD_SEG, 10'd0, 31'd0, '1, '1);
		send(OP_LOAD_SEG, 10'd1, 31'd100, 17'd65535, '0);
		send(OP_LOAD_SEG, 10'd2, 31'd100, '0, rand_tmrca());
		send(OP_LOAD_SEG, 10'd3, POS_END, 17'd7, rand_tmrca());
		send(OP_LOAD_MIS, 10'd0, 31'd50, '0, '0);
		send(OP_LOAD_MIS, 10'd1, 31'd100, '0, '0);
		send(OP_LOAD_MIS, 10'd2, 31'd100, '0, '0);
		send(OP_LOAD_MIS, 10'd3, POS_END, '0, '0);
		settle();
		write_count(REG_SEG_COUNT, 11'd4);
		write_count(REG_MIS_COUNT, 11'd4);
		send(OP_RESTART, '0, '0, '0, '0);
		query(31'd50);
		query(31'd99);
		query(31'd100);
		query(31'd101);
		query(POS_END);
		query(POS_END);

		// shrink counts below the cursors
		settle();
		write_count(REG_MIS_COUNT, 11'd1);
		query(31'd200);
		settle();
		write_count(REG_SEG_COUNT, 11'd2);
		query('0);

		// reload an entry behind a latched cursor
		settle();
		write_count(REG_SEG_COUNT, 11'd4);
		write_count(REG_MIS_COUNT, 11'd4);
		send(OP_RESTART, '0, '0, '0, '0);
		send(OP_LOAD_SEG, 10'd1, 31'd5, 17'd3, rand_tmrca());
		query(31'd10);
		query(31'd100);

		// counts above the table depth; the end entries keep the cursors in the loaded part
		settle();
		write_count(REG_SEG_COUNT, '1);
		write_count(REG_MIS_COUNT, CNT_W'(DEPTH + 1));
		send(OP_RESTART, rand_slot(), rand_pos(), rand_target(), rand_tmrca());
		query(31'd4);
		query(31'd50);
		query(31'd100);
		query(31'd101);
		query(POS_END - 31'd1);
		settle();

		random_base = sent;
		first = 1'b1;
		while (sent < random_base + RANDOM_ITEMS) begin
			quiet = (sent > random_base + RANDOM_ITEMS * 4 / 5);
			run_episode(first);
			first = 1'b0;
		end

		settle();
		repeat (16) @(posedge clk);
		if (sb.fails == 0 && sb.pending_reports.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/smsc_pkg.sv
hdl/smsc_ram.sv
hdl/smsc_ctrl.sv
hdl/smsc_dp.sv
hdl/segment_mismatch_site_cursor.sv
test/segment_mismatch_site_cursor_tb.sv
